>>> design/smiu_pkg.sv
// ----------------------------------------------------------------------------
// smiu_pkg
// Shared types, opcodes, status codes and controller commands for the
// stack-machine integer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smiu_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned DataW = 64;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_POP = 4'd1, OP_SWAP = 4'd2, OP_DUP = 4'd3,
    OP_ADD = 4'd4, OP_SUB = 4'd5, OP_MUL = 4'd6, OP_DIV = 4'd7,
    OP_CMP = 4'd8, OP_NEG = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [63:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] top_value;
    logic               top_valid;
    logic [8:0]         stack_depth;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_MUL, S_DIV, S_WR1, S_WR2, S_RDT, S_TOP, S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic rd_a;      // read top, pop into a
    logic rd_b;      // read next, pop into b
    logic cap_a;     // latch read data into a
    logic cap_b;     // latch read data into b
    logic alu;       // compute result into r
    logic mul_step;  // advance multiplier
    logic div_start;
    logic wr_r;      // push r
    logic wr_a;      // push a
    logic wr_b;      // push b
    logic rd_top;    // read new top
    logic cap_top;
    logic fin;       // build result
    logic [1:0] status;
  } smiu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic has_two;
    logic a_zero;
    logic mul_done;
    logic div_done;
  } smiu_sts_t;

endpackage

>>> design/stack_machine_integer_unit_core.sv
// ----------------------------------------------------------------------------
// stack_machine_integer_unit_core
// Top level of the stack-machine integer unit: controller plus datapath.
// ----------------------------------------------------------------------------
// Timing: the single-port stack RAM serves one pop, push or top read per cycle,
//   so each transaction is sequenced through its pops, compute, pushes and the
//   top read; mul runs four 16-bit partial-product steps, div waits on the
//   bit-serial divider, and divide by zero skips the divider.
// Throughput: one transaction at a time; the next is taken in the idle cycle
//   after the result register is loaded, while that result may still wait on
//   out_stall.
// Reset: synchronous active-low rst_n empties the stack; RAM is not cleared.
`timescale 1ns / 1ps
module stack_machine_integer_unit_core import smiu_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  smiu_cmd_t cmd;
  smiu_sts_t sts;

  // Sequence each transaction through pops, compute and pushes.
  smiu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_data.mode), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  // Hold the stack, operands and the result register.
  smiu_dp #(.StackDepth(StackDepth)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
    .out_item(out_data)
  );
endmodule

>>> design/smiu_ram.sv
// ----------------------------------------------------------------------------
// smiu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smiu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/smiu_div.sv
// ----------------------------------------------------------------------------
// smiu_div
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smiu_div import smiu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [63:0]      divisor,
  output logic             done,
  output logic [63:0]      quot
);
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt;
  logic [64:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; busy_nxt = busy_r;
    trial = {rem_r, q_r[63]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend[63] ? 64'(0 - dividend) : dividend;
      d_nxt    = divisor[63] ? 64'(0 - divisor) : divisor;
      rem_nxt  = '0;
      neg_nxt  = dividend[63] ^ divisor[63];
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], q_r[63]};
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign done = !busy_r && !start;
  assign quot = neg_r ? 64'(0 - q_r) : q_r;
endmodule

>>> design/smiu_dp.sv
// ----------------------------------------------------------------------------
// smiu_dp
// Datapath: stack memory, pointer, operand registers, ALU, multiplier,
// divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smiu_dp import smiu_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  smiu_cmd_t cmd,
  output smiu_sts_t sts,
  output out_item_t out_item
);
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   a_r, b_r, r_r, pv_r, top_r;
  logic [3:0]    mode_r;
  logic [63:0]   rdata, wdata;
  logic [AW-1:0] addr;
  logic          we;
  out_item_t     out_r;
  // multiplier: 16x64 partial products, one 16-bit digit of a per step
  logic [1:0]    mc_r;
  logic [63:0]   macc_r;
  logic [63:0]   mpart;
  logic [15:0]   mdig;
  logic [63:0]   d_q;
  logic          d_done;
  logic [63:0]   cmpv;
  logic [CW-1:0] cm1;

  assign cm1 = cnt_r - CW'(1);

  always_comb begin
    addr = '0;
    we = 1'b0;
    wdata = r_r;
    cnt_nxt = cnt_r;
    if (cmd.rd_a || cmd.rd_b || cmd.rd_top) begin
      addr = cm1[AW-1:0];
    end
    if (cmd.rd_a || cmd.rd_b) begin
      cnt_nxt = cm1;
    end
    if (cmd.wr_r || cmd.wr_a || cmd.wr_b) begin
      we = 1'b1;
      addr = cnt_r[AW-1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cmd.wr_a) begin
        wdata = a_r;
      end else if (cmd.wr_b) begin
        wdata = b_r;
      end
    end
  end

  smiu_ram #(.Width(64), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  smiu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(b_r),
    .divisor(a_r), .done(d_done), .quot(d_q)
  );

  always_comb begin
    unique case (mc_r)
      2'd0: mdig = a_r[15:0];
      2'd1: mdig = a_r[31:16];
      2'd2: mdig = a_r[47:32];
      default: mdig = a_r[63:48];
    endcase
    mpart = 64'(b_r * mdig) << {mc_r, 4'd0};
    if ($signed(b_r) > $signed(a_r)) begin
      cmpv = 64'd1;
    end else if ($signed(b_r) < $signed(a_r)) begin
      cmpv = '1;
    end else begin
      cmpv = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mc_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.mul_step) begin
        mc_r <= mc_r + 2'd1;
      end
    end
    if (cmd.load) begin
      mode_r <= in_item.mode;
      pv_r   <= in_item.push_value;
      macc_r <= '0;
    end
    if (cmd.cap_a) a_r <= rdata;
    if (cmd.cap_b) b_r <= rdata;
    if (cmd.mul_step) begin
      macc_r <= macc_r + mpart;
      r_r    <= macc_r + mpart;
    end
    if (cmd.alu) begin
      priority case (mode_r)
        OP_PUSH: r_r <= pv_r;
        OP_ADD:  r_r <= b_r + a_r;
        OP_SUB:  r_r <= b_r - a_r;
        OP_CMP:  r_r <= cmpv;
        OP_NEG:  r_r <= 64'(0 - a_r);
        OP_DIV:  r_r <= d_q;
        default: r_r <= r_r;
      endcase
    end
    if (cmd.cap_top) top_r <= rdata;
    if (cmd.fin) begin
      out_r.status      <= cmd.status;
      out_r.top_valid   <= cnt_r != '0;
      out_r.top_value   <= (cnt_r != '0) ? top_r : '0;
      out_r.stack_depth <= 9'(cnt_r);
    end
  end

  assign sts.empty    = cnt_r == '0;
  assign sts.full     = cnt_r == CW'(StackDepth);
  assign sts.has_two  = cnt_r >= CW'(2);
  assign sts.a_zero   = a_r == '0;
  assign sts.mul_done = mc_r == 2'd3;
  assign sts.div_done = d_done;
  assign out_item     = out_r;
endmodule

>>> design/smiu_ctrl.sv
// ----------------------------------------------------------------------------
// smiu_ctrl
// Controller: sequences pops, compute, pushes and the top read per opcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smiu_ctrl import smiu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [3:0] in_mode,
  output logic      out_valid,
  input  logic      out_stall,
  input  smiu_sts_t sts,
  output smiu_cmd_t cmd
);
  state_t     state_r, state_nxt;
  logic [3:0] mode_r, mode_nxt;
  logic [1:0] st_r, st_nxt;
  logic       ov_r, ov_nxt, dup2_r, dup2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    mode_r <= mode_nxt;
    st_r   <= st_nxt;
    dup2_r <= dup2_nxt;
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    st_nxt    = st_r;
    dup2_nxt  = dup2_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    cmd.status = st_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          mode_nxt  = in_mode;
          st_nxt    = ST_OK;
          dup2_nxt  = 1'b0;
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        // decide and issue the first pop (push loads its value into r instead)
        priority case (mode_r)
          OP_PUSH: begin
            if (sts.full) begin
              st_nxt = ST_OVER;
              state_nxt = S_RDT;
            end else begin
              cmd.alu = 1'b1;
              state_nxt = S_WR1;
            end
          end
          OP_POP, OP_DUP, OP_NEG, OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
          OP_CMP: begin
            if (sts.empty) begin
              st_nxt = ST_UNDER;
              state_nxt = S_RDT;
            end else begin
              cmd.rd_a = 1'b1;
              state_nxt = S_RDB;
            end
          end
          default: state_nxt = S_RDT;
        endcase
      end
      S_RDB: begin
        cmd.cap_a = 1'b1;
        if (mode_r == OP_POP) begin
          state_nxt = S_RDT;
        end else if (mode_r == OP_DUP || mode_r == OP_NEG) begin
          state_nxt = S_EXEC;
        end else if (sts.empty) begin
          st_nxt = ST_UNDER;
          state_nxt = S_RDT;
        end else begin
          cmd.rd_b = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.cap_b = (mode_r != OP_DUP) && (mode_r != OP_NEG);
        if (mode_r == OP_MUL) begin
          state_nxt = S_MUL;
        end else if (mode_r == OP_DIV) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_WR1;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_WR2;
        end
      end
      S_DIV: begin
        if (sts.a_zero) begin
          st_nxt = ST_DIVZ;
          state_nxt = S_RDT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_WR2;
          dup2_nxt = 1'b1;
        end
      end
      S_WR1: begin
        // ALU ops compute here and push in S_WR2; push, swap and dup write here
        priority case (mode_r)
          OP_PUSH: begin
            cmd.wr_r = 1'b1;
            state_nxt = S_RDT;
          end
          OP_SWAP: begin
            cmd.wr_a = 1'b1;
            state_nxt = S_WR2;
          end
          OP_DUP: begin
            cmd.wr_a = 1'b1;
            state_nxt = S_WR2;
          end
          default: begin
            cmd.alu = 1'b1;
            state_nxt = S_WR2;
          end
        endcase
      end
      S_WR2: begin
        if (mode_r == OP_DIV && !sts.div_done) begin
          state_nxt = S_WR2;
        end else if (mode_r == OP_DIV && dup2_r) begin
          cmd.alu = 1'b1;
          dup2_nxt = 1'b0;
        end else if (mode_r == OP_SWAP) begin
          cmd.wr_b = 1'b1;
          state_nxt = S_RDT;
        end else if (mode_r == OP_DUP) begin
          if (sts.full) begin
            st_nxt = ST_OVER;
          end else begin
            cmd.wr_a = 1'b1;
          end
          state_nxt = S_RDT;
        end else begin
          cmd.wr_r = 1'b1;
          state_nxt = S_RDT;
        end
      end
      S_RDT: begin
        cmd.rd_top = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        cmd.cap_top = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result has drained
        if (!ov_r || !out_stall) begin
          cmd.fin = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
